@@ design/rcag_pkg.sv @@
// rcag_pkg: shared types and codes for the region chunk address generator
`default_nettype none

package rcag_pkg;

  // number of axes carried by an input item
  localparam int unsigned IN_AXES = 3;

  // configuration register indexes and data width
  localparam int unsigned CFG_IW = 3;
  localparam int unsigned CFG_DW = 48;
  localparam logic [CFG_IW-1:0] CFG_HEADER = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_BPP    = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_AXES   = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_EXT_X  = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_EXT_Y  = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_EXT_Z  = 3'd5;

  // input operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_NEXT  = 1'b1;

  // chunk length multiply steps
  localparam logic [1:0] LEN_SEL_Y   = 2'd0;
  localparam logic [1:0] LEN_SEL_Z   = 2'd1;
  localparam logic [1:0] LEN_SEL_BPP = 2'd2;

  typedef struct packed {
    logic        op;
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [15:0] start_z;
    logic [15:0] count_x;
    logic [15:0] count_y;
    logic [15:0] count_z;
  } rcag_in_t;

  typedef struct packed {
    logic        chunk_valid;
    logic [61:0] byte_offset;
    logic [57:0] chunk_bytes;
    logic        last_chunk;
  } rcag_out_t;

  typedef struct packed {
    logic [47:0] header_offset;
    logic [10:0] bytes_per_pixel;
    logic [1:0]  axis_count;
    logic [15:0] extent_x;
    logic [15:0] extent_y;
    logic [15:0] extent_z;
  } rcag_cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       len_en;
    logic [1:0] len_sel;
    logic       chk;
    logic       issue;
    logic [1:0] axis;
    logic       emit;
  } rcag_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic       go_chunk;
    logic [1:0] used_axes;
    logic       out_free;
  } rcag_sts_t;

endpackage

`default_nettype wire

@@ design/rcag_regs.sv @@
// rcag_regs: configuration register file
`default_nettype none

module rcag_regs (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            cfg_we,
  input  wire [rcag_pkg::CFG_IW-1:0]     cfg_index,
  input  wire [rcag_pkg::CFG_DW-1:0]     cfg_wdata,
  output rcag_pkg::rcag_cfg_t            cfg
);
  import rcag_pkg::*;

  rcag_cfg_t cfg_r;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_offset   <= '0;
      cfg_r.bytes_per_pixel <= 11'd1;
      cfg_r.axis_count      <= 2'd2;
      cfg_r.extent_x        <= 16'd1;
      cfg_r.extent_y        <= 16'd1;
      cfg_r.extent_z        <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEADER: cfg_r.header_offset   <= cfg_wdata[47:0];
        CFG_BPP:    cfg_r.bytes_per_pixel <= cfg_wdata[10:0];
        CFG_AXES:   cfg_r.axis_count      <= cfg_wdata[1:0];
        CFG_EXT_X:  cfg_r.extent_x        <= cfg_wdata[15:0];
        CFG_EXT_Y:  cfg_r.extent_y        <= cfg_wdata[15:0];
        CFG_EXT_Z:  cfg_r.extent_z        <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ design/rcag_ctrl.sv @@
// rcag_ctrl: sequencing state machine for load, length, region check, offset and result
`default_nettype none

module rcag_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire                  in_op,
  output logic                 in_stall,
  input  rcag_pkg::rcag_sts_t  sts,
  output rcag_pkg::rcag_cmd_t  cmd
);
  import rcag_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LEN  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_OFF  = 3'd3;
  localparam logic [2:0] S_DRN  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  // offset pipeline has two stages behind the issue
  localparam logic [1:0] DRAIN_LAST = 2'd1;

  logic [2:0] state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cnt_nxt = 2'd0;
          if (in_op == OP_NEXT) begin
            state_nxt = S_CHK;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = S_LEN;
          end
        end
      end
      S_LEN: begin
        cmd.len_en  = 1'b1;
        cmd.len_sel = cnt_r;
        if (cnt_r == LEN_SEL_BPP) begin
          cnt_nxt   = 2'd0;
          state_nxt = S_CHK;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      S_CHK: begin
        cmd.chk   = 1'b1;
        cnt_nxt   = 2'd0;
        state_nxt = sts.go_chunk ? S_OFF : S_OUT;
      end
      S_OFF: begin
        cmd.issue = 1'b1;
        cmd.axis  = cnt_r;
        if (cnt_r == sts.used_axes - 2'd1) begin
          cnt_nxt   = 2'd0;
          state_nxt = S_DRN;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      S_DRN: begin
        if (cnt_r == DRAIN_LAST) begin
          cnt_nxt   = 2'd0;
          state_nxt = S_OUT;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // a next transfer goes straight to the region check
  a_next_to_chk: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_op == OP_NEXT) |=> state_r == S_CHK)
    else $error("next transfer did not reach region check");

  // issue counter never passes the axes in use
  a_issue_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OFF |-> cnt_r < sts.used_axes)
    else $error("offset issue beyond axes in use");

endmodule

`default_nettype wire

@@ design/rcag_dp.sv @@
// rcag_dp: region state, length and offset arithmetic, result register
`default_nettype none

module rcag_dp #(
  parameter int unsigned MAX_AXES = 3
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  rcag_pkg::rcag_cfg_t  cfg,
  input  rcag_pkg::rcag_in_t   in_data,
  input  rcag_pkg::rcag_cmd_t  cmd,
  output rcag_pkg::rcag_sts_t  sts,
  input  wire                  out_stall,
  output logic                 out_valid,
  output rcag_pkg::rcag_out_t  out_data
);
  import rcag_pkg::*;

  // axes that can ever be in use
  localparam int unsigned NA = (MAX_AXES < IN_AXES) ? MAX_AXES : IN_AXES;

  // region state
  logic [16:0] pos_r   [NA];
  logic [15:0] start_r [NA];
  logic [15:0] count_r [NA];
  logic [1:0]  step_r;
  logic [58:0] len_r;
  logic        walk_r;
  logic        chunk_r;

  // offset pipeline
  logic [31:0] stride_r;
  logic        v1_r, v2_r;
  logic [27:0] pb_r;
  logic [31:0] s1_str_r;
  logic [59:0] term_r;
  logic [61:0] acc_r;

  // result register
  logic        out_valid_r;
  rcag_out_t   out_data_r;

  // three-axis views of state, input and extents
  logic [IN_AXES-1:0][16:0] pos3;
  logic [IN_AXES-1:0][15:0] st3, cnt3, in_st3, in_cnt3, ext3;

  logic [1:0]  n_use;
  logic [IN_AXES-1:0][15:0] ld_st, ld_cnt;
  logic        ld_empty;
  logic [1:0]  ld_m;
  logic [15:0] len_op;
  logic [63:0] len_prod;
  logic [57:0] len_sat;
  logic [27:0] pb_nxt;
  logic [31:0] stride_nxt;
  logic [59:0] term_nxt;
  logic [IN_AXES-1:0][16:0] np;
  logic        s_ok;
  logic        step_last;
  logic        go;

  for (genvar g = 0; g < IN_AXES; g++) begin : g_view
    if (g < NA) begin : g_used
      assign pos3[g] = pos_r[g];
      assign st3[g]  = start_r[g];
      assign cnt3[g] = count_r[g];
    end else begin : g_pad
      assign pos3[g] = '0;
      assign st3[g]  = '0;
      assign cnt3[g] = 16'd1;
    end
  end

  assign in_st3[0]  = in_data.start_x;
  assign in_st3[1]  = in_data.start_y;
  assign in_st3[2]  = in_data.start_z;
  assign in_cnt3[0] = in_data.count_x;
  assign in_cnt3[1] = in_data.count_y;
  assign in_cnt3[2] = in_data.count_z;
  assign ext3[0]    = cfg.extent_x;
  assign ext3[1]    = cfg.extent_y;
  assign ext3[2]    = cfg.extent_z;

  // position inside the box on every axis in use
  function automatic logic in_box(input logic [IN_AXES-1:0][16:0] p,
                                  input logic [IN_AXES-1:0][15:0] s,
                                  input logic [IN_AXES-1:0][15:0] c,
                                  input logic [1:0] n);
    logic        ok;
    logic [16:0] d;
    ok = 1'b1;
    for (int i = 0; i < IN_AXES; i++) begin
      d = p[i] - {1'b0, s[i]};
      if (i < int'(n)) begin
        if (p[i] < {1'b0, s[i]}) begin
          ok = 1'b0;
        end else if (d >= {1'b0, c[i]}) begin
          ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

  // axes in use: zero acts as one, clipped to the storage
  always_comb begin
    n_use = (cfg.axis_count == 2'd0) ? 2'd1 : cfg.axis_count;
    if (n_use > 2'(NA)) begin
      n_use = 2'(NA);
    end
  end

  // region load values and merged axis count
  always_comb begin
    ld_empty = 1'b0;
    for (int i = 0; i < IN_AXES; i++) begin
      if (i < int'(n_use)) begin
        ld_st[i]  = in_st3[i];
        ld_cnt[i] = in_cnt3[i];
        if (in_cnt3[i] == 16'd0) begin
          ld_empty = 1'b1;
        end
      end else begin
        ld_st[i]  = 16'd0;
        ld_cnt[i] = 16'd1;
      end
    end
    ld_m = 2'd1;
    if ((n_use > 2'd1) && (ld_cnt[0] == ext3[0])) begin
      ld_m = 2'd2;
      if ((n_use > 2'd2) && (ld_cnt[1] == ext3[1])) begin
        ld_m = 2'd3;
      end
    end
  end

  // chunk length multiply operand, one factor a step
  always_comb begin
    case (cmd.len_sel)
      LEN_SEL_Y:   len_op = (step_r > 2'd1) ? cnt3[1] : 16'd1;
      LEN_SEL_Z:   len_op = (step_r > 2'd2) ? cnt3[2] : 16'd1;
      LEN_SEL_BPP: len_op = {5'd0, cfg.bytes_per_pixel};
      default:     len_op = 16'd1;
    endcase
  end

  assign len_prod = {16'd0, len_r[47:0]} * {48'd0, len_op};
  assign len_sat  = len_r[58] ? {58{1'b1}} : len_r[57:0];

  // offset pipeline arithmetic
  assign pb_nxt     = {11'd0, pos3[cmd.axis]} * {17'd0, cfg.bytes_per_pixel};
  assign stride_nxt = {16'd0, stride_r[15:0]} * {16'd0, ext3[cmd.axis]};
  assign term_nxt   = {32'd0, pb_r} * {28'd0, s1_str_r};

  // step the first unmerged axis with carry into higher axes
  always_comb begin
    np   = pos3;
    s_ok = (step_r < n_use);
    if (s_ok) begin
      for (int i = 0; i < IN_AXES; i++) begin
        if (2'(i) == step_r) begin
          np[i] = np[i] + 17'd1;
        end
      end
      for (int i = 0; i < IN_AXES - 1; i++) begin
        if ((2'(i) >= step_r) && ((i + 1) < int'(n_use))) begin
          if ((np[i] < {1'b0, st3[i]}) ||
              ((np[i] - {1'b0, st3[i]}) >= {1'b0, cnt3[i]})) begin
            np[i]     = {1'b0, st3[i]};
            np[i + 1] = np[i + 1] + 17'd1;
          end
        end
      end
    end
    step_last = !s_ok || !in_box(np, st3, cnt3, n_use);
  end

  assign go = walk_r && in_box(pos3, st3, cnt3, n_use);

  // region state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NA; i++) begin
        pos_r[i]   <= '0;
        start_r[i] <= '0;
        count_r[i] <= '0;
      end
      step_r  <= '0;
      len_r   <= '0;
      walk_r  <= 1'b0;
      chunk_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        for (int i = 0; i < NA; i++) begin
          start_r[i] <= ld_st[i];
          count_r[i] <= ld_cnt[i];
          pos_r[i]   <= {1'b0, ld_st[i]};
        end
        step_r <= ld_m;
        len_r  <= {43'd0, ld_cnt[0]};
        walk_r <= !ld_empty;
      end
      if (cmd.len_en) begin
        len_r <= len_prod[58:0];
      end
      if (cmd.chk) begin
        chunk_r <= go;
        if (!go) begin
          walk_r <= 1'b0;
        end
      end
      if (cmd.emit && chunk_r) begin
        for (int i = 0; i < NA; i++) begin
          pos_r[i] <= np[i];
        end
        walk_r <= !step_last;
      end
    end
  end

  // offset pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
    end
  end

  // offset pipeline data: product, scaled term, accumulate
  always_ff @(posedge clk) begin
    if (cmd.chk) begin
      acc_r    <= {14'd0, cfg.header_offset};
      stride_r <= 32'd1;
    end else begin
      if (cmd.issue) begin
        stride_r <= stride_nxt;
      end
      if (v2_r) begin
        acc_r <= acc_r + {2'd0, term_r};
      end
    end
    if (cmd.issue) begin
      pb_r     <= pb_nxt;
      s1_str_r <= stride_r;
    end
    if (v1_r) begin
      term_r <= term_nxt;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit || (out_valid_r && out_stall);
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (chunk_r) begin
        out_data_r.chunk_valid <= 1'b1;
        out_data_r.byte_offset <= acc_r;
        out_data_r.chunk_bytes <= len_sat;
        out_data_r.last_chunk  <= step_last;
      end else begin
        out_data_r <= '0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign sts.go_chunk  = go;
  assign sts.used_axes = n_use;
  assign sts.out_free  = !out_valid_r || !out_stall;

  // offset pipeline is empty when a chunk result is written
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && chunk_r |-> !v1_r && !v2_r)
    else $error("chunk written before offset pipeline drained");

  // the final chunk ends the walk
  a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && chunk_r && step_last |=> !walk_r)
    else $error("walk still active after last chunk");

endmodule

`default_nettype wire

@@ design/region_chunk_address_generator.sv @@
// region_chunk_address_generator: top level of the strided chunk address generator
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   rcag_in_t   (op, start and count per axis)
//   out_     output     out_valid / out_stall rcag_out_t  (chunk valid, offset, bytes, last)
//   cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// a next item that yields a chunk passes the region check, then the shared offset multiplier
// that handles one axis a cycle for the n axes in use plus its two-stage drain, then the
// result step; a next that yields no chunk goes from the region check to the result step.
// a start item first runs the chunk length multiplies for y, z and bytes per pixel.
// one item is in flight at a time; in_stall is high from transfer until the result is
// written into the output register, and a stalled result holds the block in its last step.
// synchronous active-low reset; no clearing pass.
`default_nettype none

module region_chunk_address_generator #(
  parameter int unsigned MAX_AXES = 3
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  rcag_pkg::rcag_in_t           in_data,
  output logic                         out_valid,
  input  wire                          out_stall,
  output rcag_pkg::rcag_out_t          out_data,
  input  wire                          cfg_we,
  input  wire [rcag_pkg::CFG_IW-1:0]   cfg_index,
  input  wire [rcag_pkg::CFG_DW-1:0]   cfg_wdata
);
  import rcag_pkg::*;

  rcag_cfg_t cfg;
  rcag_cmd_t cmd;
  rcag_sts_t sts;

  // configuration registers
  rcag_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // sequencing controller
  rcag_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic and region state
  rcag_dp #(
    .MAX_AXES (MAX_AXES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
